@@ hdl/dnsrap_pkg.sv @@
// Shared types and constants of the DNS response answer parser.
`default_nettype none
package dnsrap_pkg;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_QLEN,
    PH_QLAB,
    PH_QPTR,
    PH_QFIX,
    PH_ALEN,
    PH_ALAB,
    PH_APTR,
    PH_AFIX,
    PH_RDATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RESP_OK,
    RESP_REJECT,
    RESP_TRUNC
  } resp_status_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_IPV4,
    KIND_IPV6
  } addr_kind_t;

  localparam logic       CFG_EXPECTED_ID = 1'b0;
  localparam logic       CFG_MAX_TTL     = 1'b1;

  localparam logic [7:0]  PTR_MASK   = 8'hC0;
  localparam logic [15:0] HDR_LEN    = 16'd12;
  localparam logic [15:0] QFIX_LEN   = 16'd4;
  localparam logic [15:0] AFIX_LEN   = 16'd10;
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  localparam logic [15:0] CLASS_IN   = 16'd1;
  localparam logic [15:0] LEN_A      = 16'd4;
  localparam logic [15:0] LEN_AAAA   = 16'd16;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [31:0] max_ttl;
  } cfg_t;

  typedef struct packed {
    resp_status_t response_status;
    logic [2:0]   answer_index;
    logic         answer_status;
    addr_kind_t   address_kind;
    logic [63:0]  address_high;
    logic [63:0]  address_low;
    logic         last_result;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } step_t;

endpackage
`default_nettype wire

@@ hdl/dnsrap_if.sv @@
// Valid/ready channel interfaces for message bytes and answer results.
`default_nettype none
interface dnsrap_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface dnsrap_ans_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response_status;
  logic [2:0]  answer_index;
  logic        answer_status;
  logic [1:0]  address_kind;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic        last_result;

  modport source(output valid, response_status, answer_index, answer_status, address_kind,
                 address_high, address_low, last_result, input ready);
  modport sink(input valid, response_status, answer_index, answer_status, address_kind,
               address_high, address_low, last_result, output ready);
endinterface
`default_nettype wire

@@ hdl/dnsrap_fsm.sv @@
// Parse state and per-byte step of the DNS response parser.
`default_nettype none
module dnsrap_fsm import dnsrap_pkg::*; #(
  parameter int MAX_ANS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [7:0] dbyte,
  input  wire logic       eom,
  input  wire cfg_t       cfg,
  output step_t           step
);

  localparam int CW = $clog2(MAX_ANS + 1);

  phase_t        phase, phase_next;
  logic [15:0]   byte_cnt, byte_cnt_next;
  logic [15:0]   header_id, header_id_next;
  logic [15:0]   wanted, wanted_next;
  logic [CW-1:0] done_cnt, done_cnt_next;
  logic [7:0]    label_cnt, label_cnt_next;
  logic [15:0]   rec_type, rec_type_next;
  logic [15:0]   rec_class, rec_class_next;
  logic [31:0]   rec_ttl, rec_ttl_next;
  logic [15:0]   rec_len, rec_len_next;
  logic [63:0]   acc_hi, acc_hi_next;
  logic [63:0]   acc_lo, acc_lo_next;
  logic          ctl_ok, ctl_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      byte_cnt  <= '0;
      header_id <= '0;
      wanted    <= '0;
      done_cnt  <= '0;
      label_cnt <= '0;
    end else if (go) begin
      phase     <= phase_next;
      byte_cnt  <= byte_cnt_next;
      header_id <= header_id_next;
      wanted    <= wanted_next;
      done_cnt  <= done_cnt_next;
      label_cnt <= label_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rec_type  <= rec_type_next;
      rec_class <= rec_class_next;
      rec_ttl   <= rec_ttl_next;
      rec_len   <= rec_len_next;
      acc_hi    <= acc_hi_next;
      acc_lo    <= acc_lo_next;
      ctl_ok    <= ctl_ok_next;
    end
  end

  always_comb begin
    logic [15:0]   cnt_inc;
    logic          fin;
    logic          last;
    logic [CW-1:0] limit;
    cnt_inc        = byte_cnt + 16'd1;
    fin            = 1'b0;
    last           = 1'b0;
    limit          = (wanted < 16'(MAX_ANS)) ? wanted[CW-1:0] : CW'(MAX_ANS);
    phase_next     = phase;
    byte_cnt_next  = byte_cnt;
    header_id_next = header_id;
    wanted_next    = wanted;
    done_cnt_next  = done_cnt;
    label_cnt_next = label_cnt;
    rec_type_next  = rec_type;
    rec_class_next = rec_class;
    rec_ttl_next   = rec_ttl;
    rec_len_next   = rec_len;
    acc_hi_next    = acc_hi;
    acc_lo_next    = acc_lo;
    ctl_ok_next    = ctl_ok;
    step           = '0;

    unique case (phase) inside
      PH_HDR: begin
        if (byte_cnt < 16'd2) begin
          header_id_next = {header_id[7:0], dbyte};
        end else if (byte_cnt == 16'd6 || byte_cnt == 16'd7) begin
          wanted_next = {wanted[7:0], dbyte};
        end
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= HDR_LEN) begin
          byte_cnt_next = '0;
          if (header_id_next != cfg.expected_id || wanted_next == 16'd0) begin
            step.valid               = 1'b1;
            step.res.response_status = RESP_REJECT;
            step.res.last_result     = 1'b1;
            phase_next               = PH_DONE;
          end else begin
            phase_next = PH_QLEN;
          end
        end
      end
      PH_QLEN, PH_ALEN: begin
        if (dbyte == 8'd0) begin
          byte_cnt_next = '0;
          phase_next    = (phase == PH_QLEN) ? PH_QFIX : PH_AFIX;
        end else if ((dbyte & PTR_MASK) == PTR_MASK) begin
          phase_next = (phase == PH_QLEN) ? PH_QPTR : PH_APTR;
        end else begin
          label_cnt_next = dbyte;
          phase_next     = (phase == PH_QLEN) ? PH_QLAB : PH_ALAB;
        end
      end
      PH_QLAB, PH_ALAB: begin
        label_cnt_next = label_cnt - 8'd1;
        if (label_cnt_next == 8'd0) begin
          phase_next = (phase == PH_QLAB) ? PH_QLEN : PH_ALEN;
        end
      end
      PH_QPTR, PH_APTR: begin
        byte_cnt_next = '0;
        phase_next    = (phase == PH_QPTR) ? PH_QFIX : PH_AFIX;
      end
      PH_QFIX: begin
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= QFIX_LEN) begin
          byte_cnt_next = '0;
          phase_next    = PH_ALEN;
        end
      end
      PH_AFIX: begin
        if (byte_cnt < 16'd2) begin
          rec_type_next = {rec_type[7:0], dbyte};
        end else if (byte_cnt < 16'd4) begin
          rec_class_next = {rec_class[7:0], dbyte};
        end else if (byte_cnt < 16'd8) begin
          rec_ttl_next = {rec_ttl[23:0], dbyte};
        end else begin
          rec_len_next = {rec_len[7:0], dbyte};
        end
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= AFIX_LEN) begin
          byte_cnt_next = '0;
          ctl_ok_next   = (rec_class == CLASS_IN) && (rec_ttl <= cfg.max_ttl);
          acc_hi_next   = '0;
          acc_lo_next   = '0;
          if (rec_len_next == 16'd0) begin
            fin = 1'b1;
          end else begin
            phase_next = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        acc_hi_next   = {acc_hi[55:0], acc_lo[63:56]};
        acc_lo_next   = {acc_lo[55:0], dbyte};
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= rec_len) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      last = ({1'b0, done_cnt} + (CW+1)'(1)) >= {1'b0, limit};
      step.valid                = 1'b1;
      step.res.response_status  = RESP_OK;
      step.res.answer_index     = 3'(done_cnt);
      step.res.last_result      = last;
      if (ctl_ok_next && rec_type_next == TYPE_A && rec_len_next == LEN_A) begin
        step.res.address_kind = KIND_IPV4;
        step.res.address_low  = {32'd0, acc_lo_next[31:0]};
      end else if (ctl_ok_next && rec_type_next == TYPE_AAAA && rec_len_next == LEN_AAAA) begin
        step.res.address_kind = KIND_IPV6;
        step.res.address_high = acc_hi_next;
        step.res.address_low  = acc_lo_next;
      end else begin
        step.res.answer_status = 1'b1;
      end
      done_cnt_next = done_cnt + CW'(1);
      byte_cnt_next = '0;
      phase_next    = last ? PH_DONE : PH_ALEN;
    end

    if (eom) begin
      if (phase_next != PH_DONE) begin
        step.res.response_status = RESP_TRUNC;
        step.res.last_result     = 1'b1;
        if (!step.valid) begin
          step.valid            = 1'b1;
          step.res.answer_index = 3'(done_cnt_next);
        end
      end
      phase_next     = PH_HDR;
      byte_cnt_next  = '0;
      header_id_next = '0;
      wanted_next    = '0;
      done_cnt_next  = '0;
      label_cnt_next = '0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dns_response_answer_parser.sv @@
// Top level: DNS response answer parser, one message byte per transaction.
// An accepted byte passes the input register, then the result register, to the answer channel.
// Throughput: one byte per cycle while the answer side is ready; the input
// register and the result register each hold one transaction.
// Reset (rst, synchronous): parser returns to the header phase, expected_id 0,
// max_ttl 604800, both channels empty.
`default_nettype none
module dns_response_answer_parser import dnsrap_pkg::*; #(
  parameter int MAX_ANS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data,
  dnsrap_msg_if.sink       msg,
  dnsrap_ans_if.source     answer
);

  cfg_t       cfg;
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_eom;
  logic       advance;
  step_t      step;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id <= 16'd0;
      cfg.max_ttl     <= 32'd604800;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_EXPECTED_ID: cfg.expected_id <= wr_data[15:0];
        CFG_MAX_TTL:     cfg.max_ttl     <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign advance   = q_valid && (!answer.valid || answer.ready);
  assign msg.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (msg.ready) begin
      q_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      q_byte <= msg.data_byte;
      q_eom  <= msg.end_of_message;
    end
  end

  dnsrap_fsm #(
    .MAX_ANS(MAX_ANS)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .dbyte(q_byte),
    .eom  (q_eom),
    .cfg  (cfg),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      answer.valid <= 1'b0;
    end else if (advance && step.valid) begin
      answer.valid <= 1'b1;
    end else if (answer.ready) begin
      answer.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.valid) begin
      res <= step.res;
    end
  end

  assign answer.response_status = res.response_status;
  assign answer.answer_index    = res.answer_index;
  assign answer.answer_status   = res.answer_status;
  assign answer.address_kind    = res.address_kind;
  assign answer.address_high    = res.address_high;
  assign answer.address_low     = res.address_low;
  assign answer.last_result     = res.last_result;

`ifndef SYNTHESIS
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    answer.valid && answer.response_status == RESP_REJECT |->
      answer.last_result && answer.address_kind == KIND_NONE && answer.answer_index == 3'd0)
    else $error("reject result malformed");

  a_addr_valid: assert property (@(posedge clk) disable iff (rst)
    answer.valid && answer.address_kind != KIND_NONE |-> !answer.answer_status)
    else $error("address reported on invalid answer");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !advance |=> q_valid && $stable(q_byte) && $stable(q_eom))
    else $error("held input byte lost");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    answer.valid && answer.response_status == RESP_TRUNC |-> answer.last_result)
    else $error("truncated result not marked last");
`endif

endmodule
`default_nettype wire

@@ tb/dns_response_answer_parser_test.sv @@
// Testbench for the DNS response answer parser: directed and random messages.
`default_nettype none
module dns_response_answer_parser_test;
  import dnsrap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANSWER_LIMIT = 8;
  localparam int TOTAL_BYTES  = 1100;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic        wr_index;
  logic [31:0] wr_data;

  dnsrap_msg_if msg();
  dnsrap_ans_if answer();

  dns_response_answer_parser #(.MAX_ANS(ANSWER_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .msg(msg),
    .answer(answer)
  );

  // parser model state and register copies
  phase_t      ph;
  logic [15:0] byte_cnt;
  logic [15:0] hdr_id;
  logic [15:0] an_count;
  logic [3:0]  ans_done;
  logic [7:0]  label_left;
  logic [15:0] rr_type;
  logic [15:0] rr_class;
  logic [31:0] rr_ttl;
  logic [15:0] rr_len;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic        class_ttl_ok;
  logic [15:0] cur_id;
  logic [31:0] cur_max_ttl;

  result_t     answer_q[$];
  logic [7:0]  msg_buf[$];
  int          fail_count = 0;
  int          sent_bytes = 0;
  int          stall_len = 0;
  bit          src_idle = 1;
  bit          snk_idle = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  task automatic parser_restart();
    ph = PH_HDR;
    byte_cnt = '0;
    hdr_id = '0;
    an_count = '0;
    ans_done = '0;
    label_left = '0;
  endtask

  task automatic skip_name_byte(input logic [7:0] b, input phase_t len_ph, input phase_t lab_ph,
                                input phase_t ptr_ph, output bit ended);
    ended = 0;
    if (ph == ptr_ph) begin
      ended = 1;
    end else if (ph == lab_ph) begin
      label_left = label_left - 8'd1;
      if (label_left == 8'd0) ph = len_ph;
    end else if (b == 8'd0) begin
      ended = 1;
    end else if ((b & PTR_MASK) == PTR_MASK) begin
      ph = ptr_ph;
    end else begin
      label_left = b;
      ph = lab_ph;
    end
  endtask

  task automatic close_answer(output result_t r);
    int limit;
    bit last;
    limit = (an_count < ANSWER_LIMIT) ? int'(an_count) : ANSWER_LIMIT;
    r = '0;
    r.response_status = RESP_OK;
    r.answer_index = ans_done[2:0];
    r.address_kind = KIND_NONE;
    if (class_ttl_ok && rr_type == TYPE_A && rr_len == LEN_A) begin
      r.address_kind = KIND_IPV4;
      r.address_low = {32'h0, addr_lo[31:0]};
    end else if (class_ttl_ok && rr_type == TYPE_AAAA && rr_len == LEN_AAAA) begin
      r.address_kind = KIND_IPV6;
      r.address_high = addr_hi;
      r.address_low = addr_lo;
    end
    r.answer_status = (r.address_kind == KIND_NONE);
    last = (int'(ans_done) + 1 >= limit);
    r.last_result = last;
    ans_done = ans_done + 4'd1;
    byte_cnt = '0;
    ph = last ? PH_DONE : PH_ALEN;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eom, output bit have,
                            output result_t r);
    bit ended;
    have = 0;
    r = '0;
    case (ph)
      PH_HDR: begin
        if (byte_cnt < 16'd2) hdr_id = {hdr_id[7:0], b};
        else if (byte_cnt == 16'd6 || byte_cnt == 16'd7) an_count = {an_count[7:0], b};
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= HDR_LEN) begin
          byte_cnt = '0;
          if (hdr_id != cur_id || an_count == 16'd0) begin
            r.response_status = RESP_REJECT;
            r.last_result = 1'b1;
            have = 1;
            ph = PH_DONE;
          end else begin
            ph = PH_QLEN;
          end
        end
      end
      PH_QLEN, PH_QLAB, PH_QPTR: begin
        skip_name_byte(b, PH_QLEN, PH_QLAB, PH_QPTR, ended);
        if (ended) begin
          byte_cnt = '0;
          ph = PH_QFIX;
        end
      end
      PH_QFIX: begin
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= QFIX_LEN) begin
          byte_cnt = '0;
          ph = PH_ALEN;
        end
      end
      PH_ALEN, PH_ALAB, PH_APTR: begin
        skip_name_byte(b, PH_ALEN, PH_ALAB, PH_APTR, ended);
        if (ended) begin
          byte_cnt = '0;
          ph = PH_AFIX;
        end
      end
      PH_AFIX: begin
        if (byte_cnt < 16'd2) rr_type = {rr_type[7:0], b};
        else if (byte_cnt < 16'd4) rr_class = {rr_class[7:0], b};
        else if (byte_cnt < 16'd8) rr_ttl = {rr_ttl[23:0], b};
        else rr_len = {rr_len[7:0], b};
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= AFIX_LEN) begin
          byte_cnt = '0;
          class_ttl_ok = (rr_class == CLASS_IN) && (rr_ttl <= cur_max_ttl);
          addr_hi = '0;
          addr_lo = '0;
          if (rr_len == 16'd0) begin
            close_answer(r);
            have = 1;
          end else begin
            ph = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        addr_hi = {addr_hi[55:0], addr_lo[63:56]};
        addr_lo = {addr_lo[55:0], b};
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= rr_len) begin
          close_answer(r);
          have = 1;
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (ph != PH_DONE) begin
        if (have) begin
          r.response_status = RESP_TRUNC;
          r.last_result = 1'b1;
        end else begin
          r = '0;
          r.response_status = RESP_TRUNC;
          r.answer_index = ans_done[2:0];
          r.last_result = 1'b1;
          have = 1;
        end
      end
      parser_restart();
    end
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == CFG_EXPECTED_ID) cur_id = val[15:0];
    else cur_max_ttl = val;
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eom);
    bit have;
    result_t r;
    if (src_idle && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    msg.valid = 1'b1;
    msg.data_byte = b;
    msg.end_of_message = eom;
    do @(posedge clk); while (msg.ready !== 1'b1);
    sent_bytes++;
    parse_byte(b, eom, have, r);
    if (have) answer_q.push_back(r);
    @(negedge clk);
    msg.valid = 1'b0;
  endtask

  // cut = 0 (or cut not below the buffer size) sends the whole buffer, otherwise the message ends after cut bytes
  task automatic send_message(input int cut);
    int n;
    n = (cut > 0 && cut < msg_buf.size()) ? cut : msg_buf.size();
    for (int i = 0; i < n; i++) send_byte(msg_buf[i], i == n - 1);
    msg_buf.delete();
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] an);
    msg_buf.push_back(id[15:8]);
    msg_buf.push_back(id[7:0]);
    repeat (4) msg_buf.push_back(rand_byte());
    msg_buf.push_back(an[15:8]);
    msg_buf.push_back(an[7:0]);
    repeat (4) msg_buf.push_back(rand_byte());
  endtask

  task automatic put_label(input logic [7:0] len);
    msg_buf.push_back(len);
    repeat (len) msg_buf.push_back(rand_byte());
  endtask

  task automatic put_name(input int labels, input bit use_ptr);
    repeat (labels) put_label(8'($urandom_range(1, 6)));
    if (use_ptr) begin
      msg_buf.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
      msg_buf.push_back(rand_byte());
    end else begin
      msg_buf.push_back(8'h00);
    end
  endtask

  task automatic put_question(input int labels, input bit use_ptr);
    put_name(labels, use_ptr);
    repeat (4) msg_buf.push_back(rand_byte());
  endtask

  task automatic put_record(input logic [15:0] t, input logic [15:0] c, input logic [31:0] ttl,
                            input logic [15:0] len);
    msg_buf.push_back(t[15:8]);
    msg_buf.push_back(t[7:0]);
    msg_buf.push_back(c[15:8]);
    msg_buf.push_back(c[7:0]);
    msg_buf.push_back(ttl[31:24]);
    msg_buf.push_back(ttl[23:16]);
    msg_buf.push_back(ttl[15:8]);
    msg_buf.push_back(ttl[7:0]);
    msg_buf.push_back(len[15:8]);
    msg_buf.push_back(len[7:0]);
    repeat (len) msg_buf.push_back(rand_byte());
  endtask

  function automatic logic [31:0] pick_ttl();
    case ($urandom_range(0, 7))
      0: return cur_max_ttl;
      1: return cur_max_ttl + 32'd1;
      2: return $urandom;
      3: return 32'd0;
      default: return $urandom_range(0, cur_max_ttl);
    endcase
  endfunction

  task automatic put_random_answer();
    put_name($urandom_range(0, 3), $urandom_range(0, 2) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_record(TYPE_A, CLASS_IN, pick_ttl(), LEN_A);
      4, 5, 6: put_record(TYPE_AAAA, CLASS_IN, pick_ttl(), LEN_AAAA);
      7: put_record($urandom_range(0, 1) ? TYPE_A : TYPE_AAAA, 16'($urandom), pick_ttl(),
                    LEN_A);
      8: put_record(16'($urandom), CLASS_IN, pick_ttl(), 16'($urandom_range(0, 6)));
      default: begin
        if ($urandom_range(0, 1)) put_record(TYPE_A, CLASS_IN, pick_ttl(),
                                             16'($urandom_range(0, 6)));
        else put_record(TYPE_AAAA, CLASS_IN, pick_ttl(), LEN_A);
      end
    endcase
  endtask

  // header, a label-free question and two address records
  task automatic build_pair();
    put_header(cur_id, 16'd2);
    put_question(0, 0);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd1, LEN_A);
    put_name(0, 0);
    put_record(TYPE_AAAA, CLASS_IN, 32'd1, LEN_AAAA);
  endtask

  task automatic random_message();
    logic [15:0] id;
    logic [15:0] an;
    int n_put;
    int cut;
    id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_id;
    case ($urandom_range(0, 15))
      0: an = 16'd0;
      1: an = 16'($urandom_range(8, 65535));
      default: an = 16'($urandom_range(1, 4));
    endcase
    if (id != cur_id || an == 16'd0) n_put = 0;
    else n_put = (an < ANSWER_LIMIT) ? int'(an) : ANSWER_LIMIT;
    put_header(id, an);
    put_question($urandom_range(0, 3), $urandom_range(0, 2) == 0);
    repeat (n_put) put_random_answer();
    repeat ($urandom_range(0, 2)) msg_buf.push_back(rand_byte());
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, msg_buf.size()) : 0;
    send_message(cut);
  endtask

  task automatic noise_message();
    if ($urandom_range(0, 1)) begin
      msg_buf.push_back(cur_id[15:8]);
      msg_buf.push_back(cur_id[7:0]);
    end
    repeat ($urandom_range(1, 40)) msg_buf.push_back(rand_byte());
    send_message(0);
  endtask

  task automatic test_header_checks();
    put_header(16'h0000, 16'd2);
    put_question(1, 0);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd604800, LEN_A);
    put_name(0, 1);
    put_record(TYPE_A, CLASS_IN, 32'd604801, LEN_A);
    send_message(0);
    wait_drained();
    write_reg(CFG_EXPECTED_ID, 32'h5A5A_FFFF);
    put_header(16'hFFFE, 16'd1);
    repeat (3) msg_buf.push_back(rand_byte());
    send_message(0);
    put_header(16'h7FFF, 16'd1);
    send_message(0);
    put_header(16'hFFFF, 16'd0);
    send_message(0);
  endtask

  task automatic test_record_kinds();
    put_header(cur_id, 16'h0100);
    put_label(8'h40);
    msg_buf.push_back(8'h00);
    repeat (4) msg_buf.push_back(rand_byte());
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, 32'd604800, LEN_A);
    put_name(0, 1);
    put_record(TYPE_AAAA, CLASS_IN, 32'd0, LEN_AAAA);
    put_name(2, 1);
    put_record(TYPE_A, 16'd2, 32'd10, LEN_A);
    put_name(0, 0);
    put_record(TYPE_AAAA, CLASS_IN, 32'd604801, LEN_AAAA);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, 32'd10, LEN_AAAA);
    put_name(1, 1);
    put_record(TYPE_AAAA, CLASS_IN, 32'd10, LEN_A);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd10, 16'd0);
    put_label(8'hBF);
    msg_buf.push_back(8'h00);
    put_record(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd3);
    send_message(0);
  endtask

  task automatic test_truncation();
    build_pair();
    send_message(5);
    build_pair();
    send_message(12);
    build_pair();
    send_message(13);
    build_pair();
    send_message(30);
    build_pair();
    send_message(32);
    put_header(cur_id, 16'd2);
    put_question(0, 0);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd1, 16'd0);
    send_message(0);
    put_header(cur_id, 16'd1);
    put_question(1, 1);
    put_name(1, 0);
    put_record(TYPE_A, CLASS_IN, 32'd1, LEN_A);
    repeat (5) msg_buf.push_back(rand_byte());
    send_message(0);
    put_header(~cur_id, 16'd1);
    send_message(0);
    msg_buf.push_back(rand_byte());
    send_message(0);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    write_reg(CFG_MAX_TTL, 32'h0000_0000);
    write_reg(CFG_EXPECTED_ID, 32'hFFFF_0000);
    put_header(16'h0000, 16'd2);
    put_question(0, 0);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd0, LEN_A);
    put_name(0, 0);
    put_record(TYPE_A, CLASS_IN, 32'd1, LEN_A);
    send_message(0);
    wait_drained();
    write_reg(CFG_MAX_TTL, 32'hFFFF_FFFF);
    put_header(16'h0000, 16'd1);
    put_question(0, 1);
    put_name(0, 0);
    put_record(TYPE_AAAA, CLASS_IN, 32'hFFFF_FFFF, LEN_AAAA);
    send_message(0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    wait_drained();
    src_idle = 0;
    snk_idle = 0;
    stall_len = 300;
    put_header(cur_id, 16'd8);
    put_question(0, 0);
    for (int i = 0; i < ANSWER_LIMIT; i++) begin
      put_name(0, 0);
      put_record(TYPE_A, CLASS_IN, 32'd0, (i % 2 == 1) ? 16'd0 : LEN_A);
    end
    send_message(0);
    wait_drained();
    src_idle = 1;
    snk_idle = 1;
  endtask

  task automatic test_random_traffic();
    int msgs;
    msgs = 0;
    while (sent_bytes < TOTAL_BYTES) begin
      if (sent_bytes > TOTAL_BYTES * 9 / 10) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (msgs % 4 == 0) begin
        src_idle = ($urandom_range(0, 2) != 0);
        snk_idle = ($urandom_range(0, 2) != 0);
      end
      if (msgs % 6 == 5) begin
        wait_drained();
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_EXPECTED_ID, $urandom);
        end else begin
          case ($urandom_range(0, 3))
            0: write_reg(CFG_MAX_TTL, 32'h0000_0000);
            1: write_reg(CFG_MAX_TTL, 32'hFFFF_FFFF);
            2: write_reg(CFG_MAX_TTL, 32'd604800);
            default: write_reg(CFG_MAX_TTL, $urandom);
          endcase
        end
      end
      if ($urandom_range(0, 9) == 0) noise_message();
      else random_message();
      msgs++;
    end
  endtask

  task automatic note_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: exp st=%0d idx=%0d ast=%0d kind=%0d hi=%h lo=%h last=%0d",
               what, want.response_status, want.answer_index, want.answer_status,
               want.address_kind, want.address_high, want.address_low, want.last_result);
      $display("%s: got st=%0d idx=%0d ast=%0d kind=%0d hi=%h lo=%h last=%0d",
               what, got.response_status, got.answer_index, got.answer_status,
               got.address_kind, got.address_high, got.address_low, got.last_result);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && answer.valid === 1'b1 && answer.ready === 1'b1) begin
      got.response_status = resp_status_t'(answer.response_status);
      got.answer_index = answer.answer_index;
      got.answer_status = answer.answer_status;
      got.address_kind = addr_kind_t'(answer.address_kind);
      got.address_high = answer.address_high;
      got.address_low = answer.address_low;
      got.last_result = answer.last_result;
      if (answer_q.size() == 0) begin
        note_failure("unexpected transaction", '0, got);
      end else begin
        want = answer_q.pop_front();
        if (got.response_status !== want.response_status ||
            got.answer_index !== want.answer_index ||
            got.answer_status !== want.answer_status ||
            got.address_kind !== want.address_kind ||
            got.address_high !== want.address_high ||
            got.address_low !== want.address_low ||
            got.last_result !== want.last_result)
          note_failure("answer mismatch", want, got);
      end
    end
  end

  // answer side: random stalls, plus long hold-offs requested through stall_len
  initial begin
    answer.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_len > 0) begin
        answer.ready = 1'b0;
        stall_len--;
      end else if (snk_idle && $urandom_range(0, 5) == 0) begin
        answer.ready = 1'b0;
        stall_len = $urandom_range(0, 17);
      end else begin
        answer.ready = 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = 1'b0;
    wr_data = '0;
    msg.valid = 1'b0;
    msg.data_byte = '0;
    msg.end_of_message = 1'b0;
    parser_restart();
    rr_type = '0;
    rr_class = '0;
    rr_ttl = '0;
    rr_len = '0;
    addr_hi = '0;
    addr_lo = '0;
    class_ttl_ok = 1'b0;
    cur_id = '0;
    cur_max_ttl = 32'd604800;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_header_checks();
    test_record_kinds();
    test_truncation();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/dnsrap_pkg.sv
hdl/dnsrap_if.sv
hdl/dnsrap_fsm.sv
hdl/dns_response_answer_parser.sv
tb/dns_response_answer_parser_test.sv
